[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SDD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sdd assertion failed");
`define SDD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdd implication failed");
`define SDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdd sequence failed");
`else
`define SDD_ASSERT(lbl, clk, rst_n, prop)
`define SDD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/sdd_pkg.sv]
// Types, constants and helpers for the scroll direction debounce block.
`default_nettype none
package sdd_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);

  localparam logic [15:0] TYPE_SYNC     = 16'd0;
  localparam logic [15:0] TYPE_REL      = 16'd2;
  localparam logic [15:0] CODE_REPORT   = 16'd0;
  localparam logic [15:0] CODE_WHEEL    = 16'd8;
  localparam logic [15:0] CODE_WHEEL_HR = 16'd11;

  localparam logic [23:0] DEFAULT_TIMEOUT = 24'd400000;

  // Direction held as a 2-bit two's complement value: -1, 0 or +1.
  typedef logic [1:0] dir_t;
  localparam dir_t DIR_NONE = 2'b00;
  localparam dir_t DIR_POS  = 2'b01;
  localparam dir_t DIR_NEG  = 2'b11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAP,
    ST_LOCK,
    ST_READ,
    ST_LOAD,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic [15:0] ev_type;
    logic [15:0] ev_code;
    logic [31:0] ev_value;
    logic [47:0] ts;
  } entry_t;

  typedef struct packed {
    logic store;      // input transfer: write buffer, track batch
    logic gap_chk;    // evaluate idle gap
    logic lock_upd;   // update lock state, decide rewrite
    logic rd_issue;   // read buffer entry
    logic out_load;   // load output register
    logic advance;    // output transfer done, step read index
  } cmd_t;

  typedef struct packed {
    logic is_report;  // current input is a report event
    logic last;       // output register holds the batch's last event
  } status_t;

  function automatic logic is_wheel(input logic [15:0] ev_type, input logic [15:0] ev_code);
    is_wheel = (ev_type == TYPE_REL) && ((ev_code == CODE_WHEEL) || (ev_code == CODE_WHEEL_HR));
  endfunction

  function automatic logic is_report(input logic [15:0] ev_type, input logic [15:0] ev_code);
    is_report = (ev_type == TYPE_SYNC) && (ev_code == CODE_REPORT);
  endfunction

endpackage
`default_nettype wire

[hw/rtl/scroll_direction_debounce.sv]
// Top level of the scroll direction debounce block.
// Events are buffered until a report event (type 0, code 0) arrives; then
// the batch is judged (idle gap compare, then lock update) and replayed in
// order from the buffer, ending with the report flagged as last. Each
// replayed event goes through buffer read, output register load and
// transfer, and the transfer is held while out_stall is high. Input is
// stalled while a batch is judged or replayed. A wheel value is rewritten
// to the locked direction until a reversal repeats in two consecutive
// batches; a scroll gap beyond the timeout written on cfg_wr_data clears
// the lock (a timeout of zero means 400000 us). A buffer that fills with
// 64 events and no report is dropped.
`default_nettype none
module scroll_direction_debounce (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  [15:0]         in_event_type,
  input  wire  [15:0]         in_event_code,
  input  wire  signed [31:0]  in_event_value,
  input  wire  [47:0]         in_time_us,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [15:0]         out_type,
  output logic [15:0]         out_code,
  output logic signed [31:0]  out_value,
  output logic [47:0]         out_time_us,
  output logic                out_last_of_batch,
  input  wire                 cfg_wr_en,
  input  wire  [23:0]         cfg_wr_data
);

  sdd_pkg::cmd_t    cmd;
  sdd_pkg::status_t status;

  sdd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  sdd_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_event_type     (in_event_type),
    .in_event_code     (in_event_code),
    .in_event_value    (in_event_value),
    .in_time_us        (in_time_us),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_type          (out_type),
    .out_code          (out_code),
    .out_value         (out_value),
    .out_time_us       (out_time_us),
    .out_last_of_batch (out_last_of_batch)
  );

endmodule
`default_nettype wire

[hw/rtl/sdd_ctrl.sv]
// Controller state machine: buffering, batch judgment and replay sequencing.
`default_nettype none
`include "assert_macros.svh"
module sdd_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  wire              out_stall,
  input  sdd_pkg::status_t status,
  output sdd_pkg::cmd_t    cmd
);

  sdd_pkg::state_t state_r;
  sdd_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      sdd_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.store = 1'b1;
          if (status.is_report) begin
            state_nxt = sdd_pkg::ST_GAP;
          end
        end
      end
      sdd_pkg::ST_GAP: begin
        cmd.gap_chk = 1'b1;
        state_nxt   = sdd_pkg::ST_LOCK;
      end
      sdd_pkg::ST_LOCK: begin
        cmd.lock_upd = 1'b1;
        state_nxt    = sdd_pkg::ST_READ;
      end
      sdd_pkg::ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = sdd_pkg::ST_LOAD;
      end
      sdd_pkg::ST_LOAD: begin
        cmd.out_load = 1'b1;
        state_nxt    = sdd_pkg::ST_SEND;
      end
      sdd_pkg::ST_SEND: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.advance = 1'b1;
          state_nxt   = status.last ? sdd_pkg::ST_IDLE : sdd_pkg::ST_READ;
        end
      end
      default: begin
        state_nxt = sdd_pkg::ST_IDLE;
      end
    endcase
  end

  `SDD_ASSERT_NEXT(a_report_starts_judge, clk, rst_n, in_valid && !in_stall && status.is_report, state_r == sdd_pkg::ST_GAP)
  `SDD_ASSERT_NEXT(a_held_result_stays, clk, rst_n, out_valid && out_stall, out_valid)
  `SDD_ASSERT_NEXT(a_last_ends_batch, clk, rst_n, out_valid && !out_stall && status.last, !out_valid && !in_stall)

endmodule
`default_nettype wire

[hw/rtl/sdd_datapath.sv]
// Datapath: event buffer, direction lock state, gap check and value rewrite.
`default_nettype none
`include "assert_macros.svh"
module sdd_datapath (
  input  wire                 clk,
  input  wire                 rst_n,
  input  sdd_pkg::cmd_t       cmd,
  output sdd_pkg::status_t    status,
  input  wire  [15:0]         in_event_type,
  input  wire  [15:0]         in_event_code,
  input  wire  signed [31:0]  in_event_value,
  input  wire  [47:0]         in_time_us,
  input  wire                 cfg_wr_en,
  input  wire  [23:0]         cfg_wr_data,
  output logic [15:0]         out_type,
  output logic [15:0]         out_code,
  output logic signed [31:0]  out_value,
  output logic [47:0]         out_time_us,
  output logic                out_last_of_batch
);

  localparam int AW = sdd_pkg::ADDR_W;

  sdd_pkg::entry_t mem [sdd_pkg::BUFFER_DEPTH];
  sdd_pkg::entry_t rd_data_r;
  logic            rd_last_r;

  logic [AW-1:0] cnt_r;
  logic [AW-1:0] last_idx_r;
  logic [AW-1:0] rd_idx_r;

  logic [23:0]   timeout_r;

  logic          batch_has_r;
  sdd_pkg::dir_t batch_dir_r;
  logic [47:0]   batch_time_r;

  sdd_pkg::dir_t locked_r, locked_nxt;
  sdd_pkg::dir_t pend_r, pend_nxt;
  logic [1:0]    rc_r, rc_nxt;
  logic          seen_r;
  logic [47:0]   last_time_r;
  logic          gap_over_r, gap_over_nxt;
  logic          rewrite_r, rewrite_nxt;

  logic [15:0]        out_type_r;
  logic [15:0]        out_code_r;
  logic signed [31:0] out_value_r, out_value_nxt;
  logic [47:0]        out_time_r;
  logic               out_last_r;

  sdd_pkg::entry_t in_entry;
  logic            in_wheel;
  logic            in_report;

  assign in_entry  = '{ev_type: in_event_type, ev_code: in_event_code,
                       ev_value: in_event_value, ts: in_time_us};
  assign in_wheel  = sdd_pkg::is_wheel(in_event_type, in_event_code);
  assign in_report = sdd_pkg::is_report(in_event_type, in_event_code);

  assign status.is_report = in_report;
  assign status.last      = out_last_r;

  // Buffer: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[cnt_r] <= in_entry;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[rd_idx_r];
      rd_last_r <= (rd_idx_r == last_idx_r);
    end
  end

  // Idle gap: later timestamp only, zero timeout acts as the default.
  logic [48:0] gap_diff;
  logic [23:0] limit;
  always_comb begin
    limit        = (timeout_r == 24'd0) ? sdd_pkg::DEFAULT_TIMEOUT : timeout_r;
    gap_diff     = {1'b0, batch_time_r} - {1'b0, last_time_r};
    gap_over_nxt = seen_r && !gap_diff[48] && (gap_diff[47:0] > {24'd0, limit});
  end

  // Lock update for a batch that holds a wheel event.
  sdd_pkg::dir_t locked_base, pend_base;
  logic [1:0]    rc_base, rc_step;
  always_comb begin
    locked_base = gap_over_r ? sdd_pkg::DIR_NONE : locked_r;
    pend_base   = gap_over_r ? sdd_pkg::DIR_NONE : pend_r;
    rc_base     = gap_over_r ? 2'd0 : rc_r;
    rc_step     = (pend_base == batch_dir_r) ? rc_base + 2'd1 : 2'd1;
    locked_nxt  = locked_base;
    pend_nxt    = pend_base;
    rc_nxt      = rc_base;
    rewrite_nxt = 1'b0;
    priority if (locked_base == sdd_pkg::DIR_NONE) begin
      locked_nxt = batch_dir_r;
    end else if (batch_dir_r == locked_base) begin
      rc_nxt = 2'd0;
    end else begin
      pend_nxt = batch_dir_r;
      if (rc_step >= 2'd2) begin
        locked_nxt = batch_dir_r;
        rc_nxt     = 2'd0;
      end else begin
        rc_nxt      = rc_step;
        rewrite_nxt = 1'b1;
      end
    end
  end

  // Rewrite: saturate the magnitude, then apply the locked sign.
  logic [31:0] mag;
  always_comb begin
    if (rd_data_r.ev_value == 32'h8000_0000) begin
      mag = 32'h7FFF_FFFF;
    end else if (rd_data_r.ev_value[31]) begin
      mag = ~rd_data_r.ev_value + 32'd1;
    end else begin
      mag = rd_data_r.ev_value;
    end
    if (rewrite_r && sdd_pkg::is_wheel(rd_data_r.ev_type, rd_data_r.ev_code)) begin
      out_value_nxt = (locked_r == sdd_pkg::DIR_NEG) ? ~mag + 32'd1 : mag;
    end else begin
      out_value_nxt = rd_data_r.ev_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      last_idx_r  <= '0;
      rd_idx_r    <= '0;
      timeout_r   <= sdd_pkg::DEFAULT_TIMEOUT;
      batch_has_r <= 1'b0;
      batch_dir_r <= sdd_pkg::DIR_NONE;
      locked_r    <= sdd_pkg::DIR_NONE;
      pend_r      <= sdd_pkg::DIR_NONE;
      rc_r        <= 2'd0;
      seen_r      <= 1'b0;
      last_time_r <= '0;
      gap_over_r  <= 1'b0;
      rewrite_r   <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      if (cmd.store) begin
        if (in_report) begin
          last_idx_r <= cnt_r;
          rd_idx_r   <= '0;
          cnt_r      <= '0;
        end else if (cnt_r == AW'(sdd_pkg::BUFFER_DEPTH - 1)) begin
          // buffer full without a report: drop its contents
          cnt_r <= '0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
        if (in_wheel) begin
          batch_has_r <= 1'b1;
          batch_dir_r <= (!in_event_value[31] && (in_event_value != 32'sd0)) ?
                         sdd_pkg::DIR_POS : sdd_pkg::DIR_NEG;
        end
      end
      if (cmd.gap_chk) begin
        gap_over_r <= gap_over_nxt;
      end
      if (cmd.lock_upd) begin
        batch_has_r <= 1'b0;
        if (batch_has_r) begin
          locked_r    <= locked_nxt;
          pend_r      <= pend_nxt;
          rc_r        <= rc_nxt;
          seen_r      <= 1'b1;
          last_time_r <= batch_time_r;
          rewrite_r   <= rewrite_nxt;
        end else begin
          rewrite_r <= 1'b0;
        end
      end
      if (cmd.out_load) begin
        out_last_r <= rd_last_r;
      end
      if (cmd.advance) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store && in_wheel) begin
      batch_time_r <= in_time_us;
    end
    if (cmd.out_load) begin
      out_type_r  <= rd_data_r.ev_type;
      out_code_r  <= rd_data_r.ev_code;
      out_value_r <= out_value_nxt;
      out_time_r  <= rd_data_r.ts;
    end
  end

  assign out_type          = out_type_r;
  assign out_code          = out_code_r;
  assign out_value         = out_value_r;
  assign out_time_us       = out_time_r;
  assign out_last_of_batch = out_last_r;

  `SDD_ASSERT(a_lock_code_valid, clk, rst_n, locked_r == sdd_pkg::DIR_NONE || locked_r == sdd_pkg::DIR_POS || locked_r == sdd_pkg::DIR_NEG)
  `SDD_ASSERT_IMPL(a_rewrite_needs_lock, clk, rst_n, rewrite_r, locked_r != sdd_pkg::DIR_NONE)
  `SDD_ASSERT(a_reversal_below_two, clk, rst_n, !rc_r[1])

endmodule
`default_nettype wire
